[hw/rtl/tun_pkg.sv]
// Package for the triangle unit normal block: widths, constants, stage types.
// Used by every module under hw/rtl; no dependencies.
package tun_pkg;

   localparam int CoordW  = 16;
   localparam int DiffW   = 17;
   localparam int CrossW  = 35;
   localparam int MagW    = 34;   // |p| <= 2^34
   localparam int SumW    = 70;
   localparam int RootW   = 36;
   localparam int NumW    = MagW + 14;
   localparam int QuoW    = 15;   // quotient <= 16384
   localparam int OutW    = 16;
   localparam int UnitOne = 16384;
   localparam int QDepth  = 8;
   localparam int QPtrW   = 3;

   // front result: cross product components and their sum of squares
   typedef struct packed {
      logic signed [CrossW-1:0] px;
      logic signed [CrossW-1:0] py;
      logic signed [CrossW-1:0] pz;
      logic [SumW-1:0]          sum;
   } front_word_type;

   typedef struct packed {
      logic signed [OutW-1:0] nx;
      logic signed [OutW-1:0] ny;
      logic signed [OutW-1:0] nz;
      logic                   degen;
   } result_type;

endpackage

[hw/rtl/triangle_unit_normal_top.sv]
// Triangle face normal, Q2.14 unit vector, top level.
// Instantiates tun_front, tun_queue and tun_back; depends on tun_pkg.
// One triangle per clock is accepted while the input is not held off; each
// request passes 4 front stages, the queue and 54 back stages (37 for the root,
// 16 for the divides, 1 output register) before its result is offered. The front
// feeds an 8-word queue; the input is held off only while 8 words sit in the
// front or the queue, which happens only when the output has been stalled. The
// back pipeline advances whenever its output register is free or taken. A zero
// cross product yields (0, 16384, 0) with degenerate set.
module triangle_unit_normal_top import tun_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,  // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z from bit 0
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // normal_x, normal_y, normal_z from bit 0
   output logic         rsp_tuser   // degenerate
);

   logic           f_adv, f_valid, q_empty, b_adv, b_valid, q_rd;
   front_word_type f_word, q_word;
   logic [QPtrW:0] q_count;
   result_type     b_res;
   logic           in_acc;
   logic [QPtrW:0] pend_ff, pend_in;

   // words accepted but not yet read out of the queue; bounds queue fill
   assign f_adv      = 1'b1;
   assign in_acc     = req_tvalid && req_tready;
   assign req_tready = (pend_ff < (QPtrW+1)'(QDepth));

   always_comb begin
      pend_in = pend_ff + (QPtrW+1)'(in_acc) - (QPtrW+1)'(q_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   tun_front u_front (
      .clock, .reset, .adv(f_adv), .in_valid(in_acc),
      .in_data(req_tdata), .out_valid(f_valid), .out_word(f_word)
   );

   tun_queue u_queue (
      .clock, .reset, .wr_en(f_valid), .wr_data(f_word), .rd_en(q_rd),
      .rd_data(q_word), .empty(q_empty), .count(q_count)
   );

   assign b_adv = !b_valid || rsp_tready;
   assign q_rd  = b_adv && !q_empty;

   tun_back u_back (
      .clock, .reset, .adv(b_adv), .in_valid(q_rd), .in_word(q_word),
      .out_valid(b_valid), .out_res(b_res)
   );

   assign rsp_tvalid = b_valid;
   assign rsp_tdata  = {b_res.nz, b_res.ny, b_res.nx};
   assign rsp_tuser  = b_res.degen;

   // queue never overflows
   a_no_ovf: assert property (@(posedge clock) disable iff (reset)
      !(q_count == (QPtrW+1)'(QDepth) && f_valid && !q_rd)) else $error("queue overflow");
   // degenerate output has the up vector's y component, 16384
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:16] == 16'h4000)
      else $error("bad degenerate normal");

endmodule

[hw/rtl/tun_front.sv]
// Front part: differences, cross product, squares and their sum, pipelined.
// Depends on tun_pkg.
module tun_front import tun_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [9*CoordW-1:0]      in_data,
   output logic                     out_valid,
   output front_word_type           out_word
);

   logic signed [CoordW-1:0] c_in [9];
   logic signed [DiffW-1:0] ex_ff, ey_ff, ez_ff, fx_ff, fy_ff, fz_ff;
   logic signed [CrossW-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [CrossW-1:0] px_ff, py_ff, pz_ff, px2_ff, py2_ff, pz2_ff;
   logic [MagW-1:0] ax_in, ay_in, az_in;
   logic [2*MagW-1:0] sx_ff, sy_ff, sz_ff;
   logic [3:0] v_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) c_in[i] = in_data[i*CoordW +: CoordW];
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_comb begin
      ax_in = px_ff[CrossW-1] ? MagW'(-px_ff) : MagW'(px_ff);
      ay_in = py_ff[CrossW-1] ? MagW'(-py_ff) : MagW'(py_ff);
      az_in = pz_ff[CrossW-1] ? MagW'(-pz_ff) : MagW'(pz_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // s0: edge vectors
         ex_ff <= DiffW'(c_in[0]) - DiffW'(c_in[3]);
         ey_ff <= DiffW'(c_in[1]) - DiffW'(c_in[4]);
         ez_ff <= DiffW'(c_in[2]) - DiffW'(c_in[5]);
         fx_ff <= DiffW'(c_in[3]) - DiffW'(c_in[6]);
         fy_ff <= DiffW'(c_in[4]) - DiffW'(c_in[7]);
         fz_ff <= DiffW'(c_in[5]) - DiffW'(c_in[8]);
         // s1: partial products
         m0_ff <= CrossW'(ey_ff) * CrossW'(fz_ff);
         m1_ff <= CrossW'(fy_ff) * CrossW'(ez_ff);
         m2_ff <= CrossW'(fx_ff) * CrossW'(ez_ff);
         m3_ff <= CrossW'(ex_ff) * CrossW'(fz_ff);
         m4_ff <= CrossW'(ex_ff) * CrossW'(fy_ff);
         m5_ff <= CrossW'(fx_ff) * CrossW'(ey_ff);
         // s2: cross product
         px_ff <= m0_ff - m1_ff;
         py_ff <= m2_ff - m3_ff;
         pz_ff <= m4_ff - m5_ff;
         // s3: squares (34x34, within one multiplier budget)
         sx_ff <= (2*MagW)'(ax_in) * (2*MagW)'(ax_in);
         sy_ff <= (2*MagW)'(ay_in) * (2*MagW)'(ay_in);
         sz_ff <= (2*MagW)'(az_in) * (2*MagW)'(az_in);
         px2_ff <= px_ff;
         py2_ff <= py_ff;
         pz2_ff <= pz_ff;
      end
   end

   assign out_valid      = v_ff[3];
   assign out_word.px    = px2_ff;
   assign out_word.py    = py2_ff;
   assign out_word.pz    = pz2_ff;
   assign out_word.sum   = SumW'(sx_ff) + SumW'(sy_ff) + SumW'(sz_ff);

endmodule

[hw/rtl/tun_queue.sv]
// Short FIFO between front and back parts.
// Depends on tun_pkg.
module tun_queue import tun_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  front_word_type wr_data,
   input  logic           rd_en,
   output front_word_type rd_data,
   output logic           empty,
   output logic [QPtrW:0] count
);

   front_word_type mem_ff [QDepth];
   logic [QPtrW-1:0] wp_ff, rp_ff;
   logic [QPtrW:0]   cnt_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QPtrW+1)'(wr_en) - (QPtrW+1)'(rd_en);
      end
   end

   assign rd_data = mem_ff[rp_ff];
   assign empty   = (cnt_ff == '0);
   assign count   = cnt_ff;

endmodule

[hw/rtl/tun_back.sv]
// Back part: pipelined square root (one bit per stage) and three pipelined
// dividers (one quotient bit per stage). Depends on tun_pkg.
module tun_back import tun_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           in_valid,
   input  front_word_type in_word,
   output logic           out_valid,
   output result_type     out_res
);

   // input register + root stages, divide input + divide stages, output register
   localparam int Stages = RootW + QuoW + 3;

   // root stages
   logic [SumW-1:0]   rem_ff  [RootW+1];
   logic [RootW-1:0]  root_ff [RootW+1];
   logic signed [CrossW-1:0] rpx_ff [RootW+1];
   logic signed [CrossW-1:0] rpy_ff [RootW+1];
   logic signed [CrossW-1:0] rpz_ff [RootW+1];
   logic [Stages-1:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[Stages-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= in_word.sum;
         root_ff[0] <= '0;
         rpx_ff[0]  <= in_word.px;
         rpy_ff[0]  <= in_word.py;
         rpz_ff[0]  <= in_word.pz;
      end
   end

   // restoring root: trial (2r+1)<<2b compared, done via cand^2 = r^2 + 2rb' + b'^2
   for (genvar s = 0; s < RootW; s++) begin : g_root
      localparam int B = RootW - 1 - s;
      logic [SumW+1:0] trial;
      always_comb begin
         trial = ({2'b0, (SumW)'(root_ff[s])} << (B + 1)) + ((SumW+2)'(1) << (2 * B));
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (trial <= {2'b0, rem_ff[s]}) begin
               rem_ff[s+1]  <= rem_ff[s] - SumW'(trial);
               root_ff[s+1] <= root_ff[s] | (RootW'(1) << B);
            end else begin
               rem_ff[s+1]  <= rem_ff[s];
               root_ff[s+1] <= root_ff[s];
            end
            rpx_ff[s+1] <= rpx_ff[s];
            rpy_ff[s+1] <= rpy_ff[s];
            rpz_ff[s+1] <= rpz_ff[s];
         end
      end
   end

   // divide stages: |p|*16384 / len, quotient 15 bits
   logic [NumW-1:0]  dn_ff  [QuoW+1][3];
   logic [QuoW-1:0]  dq_ff  [QuoW+1][3];
   logic             ds_ff  [QuoW+1][3];
   logic [RootW-1:0] dl_ff  [QuoW+1];

   logic signed [CrossW-1:0] pin [3];
   assign pin[0] = rpx_ff[RootW];
   assign pin[1] = rpy_ff[RootW];
   assign pin[2] = rpz_ff[RootW];

   always_ff @(posedge clock) begin
      if (adv) begin
         dl_ff[0] <= root_ff[RootW];
         for (int c = 0; c < 3; c++) begin
            ds_ff[0][c] <= pin[c][CrossW-1];
            dn_ff[0][c] <= {(pin[c][CrossW-1] ? MagW'(-pin[c]) : MagW'(pin[c])), 14'd0};
            dq_ff[0][c] <= '0;
         end
      end
   end

   for (genvar s = 0; s < QuoW; s++) begin : g_div
      localparam int B = QuoW - 1 - s;
      always_ff @(posedge clock) begin
         if (adv) begin
            dl_ff[s+1] <= dl_ff[s];
            for (int c = 0; c < 3; c++) begin
               ds_ff[s+1][c] <= ds_ff[s][c];
               if ((NumW+QuoW)'(dl_ff[s]) << B <= (NumW+QuoW)'(dn_ff[s][c])) begin
                  dn_ff[s+1][c] <= dn_ff[s][c] - NumW'((NumW+QuoW)'(dl_ff[s]) << B);
                  dq_ff[s+1][c] <= dq_ff[s][c] | (QuoW'(1) << B);
               end else begin
                  dn_ff[s+1][c] <= dn_ff[s][c];
                  dq_ff[s+1][c] <= dq_ff[s][c];
               end
            end
         end
      end
   end

   // final: sign and degenerate case
   logic [OutW-1:0] nv_in [3];
   logic            dg_in;
   result_type      res_ff;
   always_comb begin
      dg_in = (dl_ff[QuoW] == '0);
      for (int c = 0; c < 3; c++) begin
         nv_in[c] = ds_ff[QuoW][c] ? OutW'(-{1'b0, dq_ff[QuoW][c]})
                                   : OutW'({1'b0, dq_ff[QuoW][c]});
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff.degen <= dg_in;
         res_ff.nx    <= dg_in ? '0 : nv_in[0];
         res_ff.ny    <= dg_in ? OutW'(UnitOne) : nv_in[1];
         res_ff.nz    <= dg_in ? '0 : nv_in[2];
      end
   end

   assign out_valid = v_ff[Stages-1];
   assign out_res   = res_ff;

endmodule

[tb/tb.sv]
// Testbench for triangle_unit_normal_top: random and directed triangles in,
// Q2.14 unit normals out, checked against a local predictor.
// Depends on the RTL under hw/rtl (tun_pkg, triangle_unit_normal_top).
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               degen;
   } normal_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;
   logic         rsp_tuser;

   logic [143:0]    tri_queue[$];
   normal_word_type normal_queue[$];
   int              err_count = 0;
   bit              feed_done = 0;
   int              hold_cycles = 0;
   bit              in_taken = 0;

   triangle_unit_normal_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   // floor square root by bit-by-bit trial
   function automatic logic [35:0] floor_root(input logic [71:0] s);
      logic [35:0] r;
      logic [35:0] c;
      r = '0;
      for (int b = 35; b >= 0; b--) begin
         c = r | (36'd1 << b);
         if ({36'd0, c} * {36'd0, c} <= s) r = c;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] unit_comp(input logic signed [35:0] p,
                                                    input logic [35:0] len);
      logic [63:0] m;
      logic [63:0] q;
      m = (p < 0) ? -p : p;
      q = (m * 64'd16384) / len;
      if (p < 0) q = -q;
      return q[15:0];
   endfunction

   function automatic normal_word_type face_normal(input logic [143:0] t);
      logic signed [35:0] v[9];
      logic signed [35:0] ex, ey, ez, fx, fy, fz, px, py, pz;
      logic signed [71:0] wx, wy, wz;
      logic [71:0]        s;
      logic [35:0]        len;
      normal_word_type    n;
      for (int i = 0; i < 9; i++) v[i] = $signed(t[16*i +: 16]);
      ex = v[0] - v[3]; ey = v[1] - v[4]; ez = v[2] - v[5];
      fx = v[3] - v[6]; fy = v[4] - v[7]; fz = v[5] - v[8];
      px = ey * fz - fy * ez;
      py = fx * ez - ex * fz;
      pz = ex * fy - fx * ey;
      wx = px; wy = py; wz = pz;
      s = wx * wx + wy * wy + wz * wz;
      len = floor_root(s);
      if (len == 0) begin
         n = '{16'sd0, 16'sd16384, 16'sd0, 1'b1};
      end else begin
         n = '{unit_comp(px, len), unit_comp(py, len), unit_comp(pz, len), 1'b0};
      end
      return n;
   endfunction

   function automatic logic [143:0] pack_tri(input logic [15:0] c[9]);
      logic [143:0] t;
      for (int i = 0; i < 9; i++) t[16*i +: 16] = c[i];
      return t;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      err_count++;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // stimulus
   initial begin
      logic [15:0] c[9];
      logic [15:0] ext[4];
      int k;
      ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
      for (int i = 0; i < 9; i++) c[i] = 16'h0000;
      tri_queue.insert(tri_queue.size(), pack_tri(c));  // all coincident
      c = '{16'd1, 16'd2, 16'd3, 16'd2, 16'd4, 16'd6, 16'd3, 16'd6, 16'd9};
      tri_queue.insert(tri_queue.size(), pack_tri(c));  // collinear
      c = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0};
      tri_queue.insert(tri_queue.size(), pack_tri(c));  // axis-aligned, full-scale
      c = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0};
      tri_queue.insert(tri_queue.size(), pack_tri(c));  // opposite winding
      for (int j = 0; j < 6; j++) begin
         for (int i = 0; i < 9; i++) c[i] = ((i / 3) == (j % 3)) ? ext[j % 2] : ext[1 - j % 2];
         tri_queue.insert(tri_queue.size(), pack_tri(c));
      end
      for (int j = 0; j < 10; j++) begin
         for (int i = 0; i < 9; i++) c[i] = ext[$urandom_range(0, 3)];
         tri_queue.insert(tri_queue.size(), pack_tri(c));
      end
      // random part: mostly full range, some small and some degenerate
      for (int n = 0; n < 1750; n++) begin
         k = $urandom_range(0, 9);
         for (int i = 0; i < 9; i++) begin
            if (k < 6) c[i] = 16'($urandom);
            else if (k < 8) c[i] = 16'($urandom_range(0, 15) - 8);
            else c[i] = ext[$urandom_range(0, 3)];
         end
         if (k == 9) for (int i = 6; i < 9; i++) c[i] = c[i-3];  // repeated vertex
         tri_queue.insert(tri_queue.size(), pack_tri(c));
      end
      feed_done = 1;
   end

   // input side: note each accepted word and predict its result
   always @(posedge clock) begin
      in_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         normal_queue.insert(normal_queue.size(), face_normal(req_tdata));
   end

   // driver
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !in_taken) begin
         // hold the offered word
      end else begin
         if (req_tvalid) begin
            send_gap = gap_len();
         end
         if (send_gap == 0 && tri_queue.size() > 0) begin
            req_tdata  <= tri_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
            if (send_gap > 0) send_gap--;
         end
      end
   end

   // receiver readiness: one long hold-off, then random stalls
   int stall_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles < 600 && tri_queue.size() < 1500) begin
         hold_cycles++;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = gap_len();
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      normal_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (normal_queue.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
         end else begin
            want = normal_queue.pop_front();
            if ($signed(rsp_tdata[15:0]) != want.nx)
               report_mismatch("normal_x", $signed(rsp_tdata[15:0]), want.nx);
            if ($signed(rsp_tdata[31:16]) != want.ny)
               report_mismatch("normal_y", $signed(rsp_tdata[31:16]), want.ny);
            if ($signed(rsp_tdata[47:32]) != want.nz)
               report_mismatch("normal_z", $signed(rsp_tdata[47:32]), want.nz);
            if (rsp_tuser != want.degen)
               report_mismatch("degenerate", rsp_tuser, want.degen);
         end
      end
   end

   // reset, then wait for drain
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (feed_done && tri_queue.size() == 0 && !req_tvalid);
      wait (normal_queue.size() == 0);
      repeat (100) @(posedge clock);
      if (err_count == 0 && normal_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("FAIL");
      $finish;
   end
endmodule
